>>> hw/rtl/plc_pkg.sv
`default_nettype none

package plc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_W      = 32;
  localparam int LOSS_SCALE = 10000;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_RTT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_RTT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LOSS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LOSS   = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_WARN = 2'd1;
  localparam logic [1:0] STATUS_CRIT = 2'd2;

  typedef struct packed {
    logic        replied;
    logic [23:0] rtt_us;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  sent_count;
    logic [7:0]  received_count;
    logic [23:0] min_rtt_us;
    logic [23:0] max_rtt_us;
    logic [23:0] avg_rtt_us;
    logic [13:0] loss_centi_pct;
  } out_word_t;

  typedef struct packed {
    logic [23:0] warn_rtt_us;
    logic [23:0] crit_rtt_us;
    logic [13:0] warn_loss;
    logic [13:0] crit_loss;
  } thresh_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_AVG,
    BK_LOSS,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/plc_queue.sv
`default_nettype none

module plc_queue #(
  parameter int WIDTH = 96
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plc_front.sv
`default_nettype none

module plc_front
  import plc_pkg::*;
#(
  parameter int RTT_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  input  wire logic [7:0] probe_count,
  input  wire logic       q_full,
  output logic            q_push,
  output logic [2*COUNT_BITS+32+2*RTT_BITS-1:0] q_wdata
);

  localparam logic [15:0] CNT_MAX = 16'((32'd1 << COUNT_BITS) - 32'd1);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [RTT_BITS-1:0] RTT_ONES = '1;

  logic [COUNT_BITS-1:0] probes;
  logic [COUNT_BITS-1:0] replies;
  logic [31:0]           total;
  logic [RTT_BITS-1:0]   low;
  logic [RTT_BITS-1:0]   high;

  logic [15:0]           tgt_wide;
  logic [COUNT_BITS-1:0] target;
  logic [31:0]           rtt_wide;
  logic [RTT_BITS-1:0]   rtt;
  logic [32:0]           sum;
  logic                  accept;
  logic                  done;

  logic [COUNT_BITS-1:0] probes_next;
  logic [COUNT_BITS-1:0] replies_next;
  logic [31:0]           total_next;
  logic [RTT_BITS-1:0]   low_next;
  logic [RTT_BITS-1:0]   high_next;

  always_comb begin
    tgt_wide = {8'd0, probe_count};
    if (tgt_wide == 16'd0) begin
      tgt_wide = 16'd1;
    end
    if (tgt_wide > CNT_MAX) begin
      tgt_wide = CNT_MAX;
    end
    target = tgt_wide[COUNT_BITS-1:0];
  end

  assign rtt_wide = 32'(in_data.rtt_us);
  assign rtt      = rtt_wide[RTT_BITS-1:0];
  assign sum      = {1'b0, total} + 33'(rtt);

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  // stats including the current word
  always_comb begin
    probes_next  = probes + CNT_ONE;
    replies_next = replies;
    total_next   = total;
    low_next     = low;
    high_next    = high;
    if (in_data.replied) begin
      replies_next = replies + CNT_ONE;
      total_next   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (rtt < low) begin
        low_next = rtt;
      end
      if (rtt > high) begin
        high_next = rtt;
      end
    end
  end

  assign done    = probes_next >= target;
  assign q_push  = accept & done;
  assign q_wdata = {probes_next, replies_next, total_next, low_next, high_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      probes  <= '0;
      replies <= '0;
      total   <= '0;
      low     <= RTT_ONES;
      high    <= '0;
    end else if (accept) begin
      if (done) begin
        probes  <= '0;
        replies <= '0;
        total   <= '0;
        low     <= RTT_ONES;
        high    <= '0;
      end else begin
        probes  <= probes_next;
        replies <= replies_next;
        total   <= total_next;
        low     <= low_next;
        high    <= high_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plc_div.sv
`default_nettype none

module plc_div
  import plc_pkg::*;
#(
  parameter int DIVISOR_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [DIV_W-1:0]        dividend,
  input  wire logic [DIVISOR_BITS-1:0] divisor,
  output logic                         done,
  output logic      [DIV_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dvs;
  logic [DIVISOR_BITS:0]   shifted;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quotient[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      rem      <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plc_back.sv
`default_nettype none

module plc_back
  import plc_pkg::*;
#(
  parameter int RTT_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  input  wire logic [2*COUNT_BITS+32+2*RTT_BITS-1:0] q_rdata,
  output logic           q_pop,
  input  wire thresh_t   thresh,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int HIGH_LSB  = 0;
  localparam int LOW_LSB   = RTT_BITS;
  localparam int TOTAL_LSB = 2 * RTT_BITS;
  localparam int RECV_LSB  = TOTAL_LSB + 32;
  localparam int SENT_LSB  = RECV_LSB + COUNT_BITS;

  back_state_t state;
  back_state_t state_next;

  logic [COUNT_BITS-1:0] sent;
  logic [COUNT_BITS-1:0] recv;
  logic [RTT_BITS-1:0]   low;
  logic [RTT_BITS-1:0]   high;
  logic [DIV_W-1:0]      numer;
  logic [DIV_W-1:0]      avg;

  logic [COUNT_BITS-1:0]    h_sent;
  logic [COUNT_BITS-1:0]    h_recv;
  logic [COUNT_BITS+13:0]   h_numer;

  logic                  load_rec;
  logic                  load_avg;
  logic                  load_out;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;

  logic                  no_reply;
  logic [DIV_W-1:0]      avg_eff;
  logic [DIV_W-1:0]      loss;
  logic [1:0]            status;
  logic [31:0]           sent_w;
  logic [31:0]           recv_w;
  logic [31:0]           low_w;
  logic [31:0]           high_w;

  assign h_sent  = q_rdata[SENT_LSB +: COUNT_BITS];
  assign h_recv  = q_rdata[RECV_LSB +: COUNT_BITS];
  assign h_numer = (COUNT_BITS + 14)'(h_sent - h_recv) * (COUNT_BITS + 14)'(LOSS_SCALE);

  plc_div #(
    .DIVISOR_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    load_rec     = 1'b0;
    load_avg     = 1'b0;
    load_out     = 1'b0;
    div_start    = 1'b0;
    div_dividend = q_rdata[TOTAL_LSB +: 32];
    div_divisor  = h_recv;
    out_valid    = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          load_rec   = 1'b1;
          div_start  = 1'b1;
          state_next = BK_AVG;
        end
      end
      BK_AVG: begin
        if (div_done) begin
          load_avg     = 1'b1;
          div_start    = 1'b1;
          div_dividend = numer;
          div_divisor  = sent;
          state_next   = BK_LOSS;
        end
      end
      BK_LOSS: begin
        if (div_done) begin
          load_out   = 1'b1;
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // report fields and status, formed as the loss quotient lands
  assign no_reply = (recv == '0);
  assign avg_eff  = no_reply ? '0 : avg;
  assign loss     = div_quo;

  always_comb begin
    status = STATUS_OK;
    if (thresh.crit_loss != '0 && loss >= DIV_W'(thresh.crit_loss)) begin
      status = STATUS_CRIT;
    end else if (thresh.crit_rtt_us != '0 && avg_eff >= DIV_W'(thresh.crit_rtt_us)) begin
      status = STATUS_CRIT;
    end else if (thresh.warn_loss != '0 && loss >= DIV_W'(thresh.warn_loss)) begin
      status = STATUS_WARN;
    end else if (thresh.warn_rtt_us != '0 && avg_eff >= DIV_W'(thresh.warn_rtt_us)) begin
      status = STATUS_WARN;
    end
  end

  assign sent_w = 32'(sent);
  assign recv_w = 32'(recv);
  assign low_w  = no_reply ? 32'd0 : 32'(low);
  assign high_w = no_reply ? 32'd0 : 32'(high);

  always_ff @(posedge clk) begin
    if (load_rec) begin
      sent  <= h_sent;
      recv  <= h_recv;
      low   <= q_rdata[LOW_LSB +: RTT_BITS];
      high  <= q_rdata[HIGH_LSB +: RTT_BITS];
      numer <= DIV_W'(h_numer);
    end
    if (load_avg) begin
      avg <= div_quo;
    end
    if (load_out) begin
      out_data.status         <= status;
      out_data.sent_count     <= sent_w[7:0];
      out_data.received_count <= recv_w[7:0];
      out_data.min_rtt_us     <= low_w[23:0];
      out_data.max_rtt_us     <= high_w[23:0];
      out_data.avg_rtt_us     <= avg_eff[23:0];
      out_data.loss_centi_pct <= loss[13:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/probe_latency_stats_classifier_core.sv
`default_nettype none

// Probe statistics: each input word is one probe outcome. The front end takes
// one word per clock while its two-entry report queue has room. A closing word
// pushes a report snapshot into the queue and the back end turns it into one
// output word using a single shared bit-serial divider, run twice (average RTT,
// then loss), and waits for out_ready before it takes the next report from the
// queue. Reports are delivered in order; configuration writes via
// cfg_we/cfg_index/cfg_data take effect at the next clock edge.

module probe_latency_stats_classifier_core
  import plc_pkg::*;
#(
  parameter int RTT_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int REC_W = 2 * COUNT_BITS + 32 + 2 * RTT_BITS;

  logic [7:0] probe_count;
  thresh_t    thresh;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [REC_W-1:0] q_wdata;
  logic [REC_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_count <= 8'd5;
      thresh      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROBE_COUNT: probe_count        <= cfg_data[7:0];
        CFG_WARN_RTT:    thresh.warn_rtt_us <= cfg_data;
        CFG_CRIT_RTT:    thresh.crit_rtt_us <= cfg_data;
        CFG_WARN_LOSS:   thresh.warn_loss   <= cfg_data[13:0];
        CFG_CRIT_LOSS:   thresh.crit_loss   <= cfg_data[13:0];
        default:         probe_count        <= probe_count;
      endcase
    end
  end

  plc_front #(
    .RTT_BITS   (RTT_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .probe_count (probe_count),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  plc_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  plc_back #(
    .RTT_BITS   (RTT_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .thresh    (thresh),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/plc_checker.sv
`default_nettype none

module plc_checker
  import plc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= STATUS_CRIT)
    else $error("undefined status code");

  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.loss_centi_pct <= 14'd10000)
    else $error("loss above one hundred percent");

  a_no_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.received_count == 8'd0 |->
      out_data.min_rtt_us == 24'd0 && out_data.max_rtt_us == 24'd0 &&
      out_data.avg_rtt_us == 24'd0)
    else $error("nonzero RTT stats in a report with no replies");

endmodule

bind probe_latency_stats_classifier_core plc_checker u_plc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
